/* rtl/ccfc_pkg.sv */
// ccfc_pkg: shared types and constants of the CAN command frame checker
// verdict codes, register indexes and field widths; no dependencies
package ccfc_pkg;

    // default width of the six event counters
    localparam int CCFC_COUNT_WIDTH = 32;

    // widths fixed by the frame and result fields
    localparam int ID_W        = 29;
    localparam int TIMEOUT_W   = 16;
    localparam int TIME_W      = 32;
    localparam int OUT_COUNT_W = 32;
    localparam int NUM_EVENTS  = 6;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_ID = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_MS = 4'd1;

    // reset values of the registers
    localparam logic [ID_W-1:0]      COMMAND_ID_RESET = '0;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 16'd100;

    // only a two-byte data field is a command
    localparam logic [3:0] CMD_DLC = 4'd2;
    // enable byte may be 0 or 1
    localparam logic [7:0] ENABLE_MAX = 8'd1;

    // verdict codes; event counter slot i counts verdict i+1
    typedef enum logic [2:0] {
        VERDICT_QUERY       = 3'd0,
        VERDICT_ACCEPT      = 3'd1,
        VERDICT_BAD_ID      = 3'd2,
        VERDICT_BAD_TYPE    = 3'd3,
        VERDICT_BAD_LENGTH  = 3'd4,
        VERDICT_BAD_VALUE   = 3'd5,
        VERDICT_BAD_COUNTER = 3'd6
    } verdict_t;

endpackage

/* rtl/can_command_frame_checker_unit.sv */
// can_command_frame_checker_unit: top level of the CAN command frame checker
// depends on ccfc_pkg
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  s_      | s_valid/s_ready, frame or query word     | in
//  m_      | m_valid/m_ready, verdict and status word | out
//  cfg_    | cfg_valid/cfg_ready, cfg_index, cfg_data | in
//
// one word per cycle sustained while the result side keeps m_ready high; a word is held
// in the input register and its result is then registered in the output register
// the checks, the age subtraction and the counter increment sit between the
// input register and the output register; stored state updates on the same edge
// a stalled result holds in the output register while the input register
// still takes a word; reset clears valid flags, stored command and counters
// cfg_ready is always high; writes to indexes beyond the list are dropped
module can_command_frame_checker_unit
    import ccfc_pkg::*;
#(
    parameter int COUNT_WIDTH = CCFC_COUNT_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_action,
    input  logic [ID_W-1:0]        s_frame_id,
    input  logic                   s_is_extended,
    input  logic                   s_is_remote,
    input  logic [3:0]             s_dlc,
    input  logic [7:0]             s_enable_byte,
    input  logic [7:0]             s_counter_byte,
    input  logic [TIME_W-1:0]      s_now_ms,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_verdict,
    output logic                   m_enable_out,
    output logic                   m_fresh,
    output logic [7:0]             m_last_counter,
    output logic [OUT_COUNT_W-1:0] m_count_accepted,
    output logic [OUT_COUNT_W-1:0] m_count_bad_id,
    output logic [OUT_COUNT_W-1:0] m_count_bad_type,
    output logic [OUT_COUNT_W-1:0] m_count_bad_length,
    output logic [OUT_COUNT_W-1:0] m_count_bad_value,
    output logic [OUT_COUNT_W-1:0] m_count_bad_counter,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [ID_W-1:0]      command_id_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // input register
    logic                 in_valid_reg;
    logic                 in_action_reg;
    logic [ID_W-1:0]      in_frame_id_reg;
    logic                 in_is_extended_reg;
    logic                 in_is_remote_reg;
    logic [3:0]           in_dlc_reg;
    logic [7:0]           in_enable_byte_reg;
    logic [7:0]           in_counter_byte_reg;
    logic [TIME_W-1:0]    in_now_ms_reg;

    // stored command
    logic                 cmd_valid_reg,   cmd_valid_next;
    logic                 cmd_enable_reg,  cmd_enable_next;
    logic [7:0]           rolling_reg,     rolling_next;
    logic [TIME_W-1:0]    accept_time_reg, accept_time_next;

    // event counters
    logic [COUNT_WIDTH-1:0] event_count_reg  [NUM_EVENTS];
    logic [COUNT_WIDTH-1:0] event_count_next [NUM_EVENTS];
    logic [OUT_COUNT_W-1:0] event_view       [NUM_EVENTS];

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             out_verdict_reg;
    logic                   out_enable_reg;
    logic                   out_fresh_reg;
    logic [7:0]             out_counter_reg;
    logic [OUT_COUNT_W-1:0] out_count_reg [NUM_EVENTS];

    logic                 advance;
    logic [TIME_W-1:0]    age;
    logic                 fresh_now;
    logic                 counter_ok;
    logic                 is_accept;
    verdict_t             verdict;

    // word moves from input to output register when the output is free
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_id_reg <= COMMAND_ID_RESET;
            timeout_reg    <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_COMMAND_ID: command_id_reg <= cfg_data[ID_W-1:0];
                REG_TIMEOUT_MS: timeout_reg    <= cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_action_reg       <= s_action;
            in_frame_id_reg     <= s_frame_id;
            in_is_extended_reg  <= s_is_extended;
            in_is_remote_reg    <= s_is_remote;
            in_dlc_reg          <= s_dlc;
            in_enable_byte_reg  <= s_enable_byte;
            in_counter_byte_reg <= s_counter_byte;
            in_now_ms_reg       <= s_now_ms;
        end
    end

    // freshness of the stored command at the word's time stamp
    assign age        = in_now_ms_reg - accept_time_reg;
    assign fresh_now  = cmd_valid_reg && (age <= TIME_W'(timeout_reg));
    assign counter_ok = in_counter_byte_reg == (rolling_reg + 8'd1);

    // checks in priority order
    always_comb begin
        verdict = VERDICT_QUERY;
        if (!in_action_reg) begin
            if (in_frame_id_reg != command_id_reg) begin
                verdict = VERDICT_BAD_ID;
            end else if (in_is_extended_reg || in_is_remote_reg) begin
                verdict = VERDICT_BAD_TYPE;
            end else if (in_dlc_reg != CMD_DLC) begin
                verdict = VERDICT_BAD_LENGTH;
            end else if (in_enable_byte_reg > ENABLE_MAX) begin
                verdict = VERDICT_BAD_VALUE;
            end else if (fresh_now && !counter_ok) begin
                verdict = VERDICT_BAD_COUNTER;
            end else begin
                verdict = VERDICT_ACCEPT;
            end
        end
    end

    assign is_accept = (verdict == VERDICT_ACCEPT);

    // stored command update
    always_comb begin
        cmd_valid_next   = cmd_valid_reg;
        cmd_enable_next  = cmd_enable_reg;
        rolling_next     = rolling_reg;
        accept_time_next = accept_time_reg;
        if (is_accept) begin
            cmd_valid_next   = 1'b1;
            cmd_enable_next  = in_enable_byte_reg[0];
            rolling_next     = in_counter_byte_reg;
            accept_time_next = in_now_ms_reg;
        end
    end

    // event counters, one slot per rejecting or accepting verdict
    for (genvar i = 0; i < NUM_EVENTS; i++) begin : g_event
        assign event_count_next[i] = (verdict == verdict_t'(3'(i + 1)))
                                   ? event_count_reg[i] + COUNT_WIDTH'(1)
                                   : event_count_reg[i];
        assign event_view[i] = OUT_COUNT_W'(event_count_next[i]);
    end

    // output valid: set by an advancing word, cleared when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // stored state, counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg   <= 1'b0;
            cmd_enable_reg  <= 1'b0;
            rolling_reg     <= '0;
            accept_time_reg <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_EVENTS; i++) begin
                event_count_reg[i] <= '0;
            end
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                cmd_valid_reg   <= cmd_valid_next;
                cmd_enable_reg  <= cmd_enable_next;
                rolling_reg     <= rolling_next;
                accept_time_reg <= accept_time_next;
                for (int i = 0; i < NUM_EVENTS; i++) begin
                    event_count_reg[i] <= event_count_next[i];
                end
            end
        end
        if (advance) begin
            out_verdict_reg <= verdict;
            out_enable_reg  <= cmd_enable_next;
            // an accepted frame is fresh by definition (age zero)
            out_fresh_reg   <= is_accept || fresh_now;
            out_counter_reg <= rolling_next;
            for (int i = 0; i < NUM_EVENTS; i++) begin
                out_count_reg[i] <= event_view[i];
            end
        end
    end

    // result ports
    assign m_valid             = out_valid_reg;
    assign m_verdict           = out_verdict_reg;
    assign m_enable_out        = out_enable_reg;
    assign m_fresh             = out_fresh_reg;
    assign m_last_counter      = out_counter_reg;
    assign m_count_accepted    = out_count_reg[0];
    assign m_count_bad_id      = out_count_reg[1];
    assign m_count_bad_type    = out_count_reg[2];
    assign m_count_bad_length  = out_count_reg[3];
    assign m_count_bad_value   = out_count_reg[4];
    assign m_count_bad_counter = out_count_reg[5];

endmodule

/* rtl/ccfc_checker.sv */
// ccfc_checker: port-level assertions for can_command_frame_checker_unit
// depends on ccfc_pkg; bound to the top level at the end of this file
module ccfc_checker
    import ccfc_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [2:0]             m_verdict,
    input logic                   m_enable_out,
    input logic                   m_fresh,
    input logic [7:0]             m_last_counter,
    input logic [OUT_COUNT_W-1:0] m_count_accepted,
    input logic [OUT_COUNT_W-1:0] m_count_bad_id,
    input logic [OUT_COUNT_W-1:0] m_count_bad_type,
    input logic [OUT_COUNT_W-1:0] m_count_bad_length,
    input logic [OUT_COUNT_W-1:0] m_count_bad_value,
    input logic [OUT_COUNT_W-1:0] m_count_bad_counter
);

    // last delivered status word
    logic                   seen_reg;
    logic                   prev_enable_reg;
    logic [7:0]             prev_counter_reg;
    logic [OUT_COUNT_W-1:0] prev_count_reg [NUM_EVENTS];
    logic                   query_word;
    logic                   status_same;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            seen_reg <= 1'b1;
        end
        if (m_valid && m_ready) begin
            prev_enable_reg   <= m_enable_out;
            prev_counter_reg  <= m_last_counter;
            prev_count_reg[0] <= m_count_accepted;
            prev_count_reg[1] <= m_count_bad_id;
            prev_count_reg[2] <= m_count_bad_type;
            prev_count_reg[3] <= m_count_bad_length;
            prev_count_reg[4] <= m_count_bad_value;
            prev_count_reg[5] <= m_count_bad_counter;
        end
    end

    assign query_word  = m_valid && m_ready && seen_reg && (m_verdict == VERDICT_QUERY);
    assign status_same = (m_enable_out == prev_enable_reg)
                      && (m_last_counter == prev_counter_reg)
                      && (m_count_accepted == prev_count_reg[0])
                      && (m_count_bad_id == prev_count_reg[1])
                      && (m_count_bad_type == prev_count_reg[2])
                      && (m_count_bad_length == prev_count_reg[3])
                      && (m_count_bad_value == prev_count_reg[4])
                      && (m_count_bad_counter == prev_count_reg[5]);

    // a stalled result word holds its verdict, fresh flag and accepted count
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict) && $stable(m_fresh)
                                && $stable(m_count_accepted))
        else $error("result word changed while stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a just-accepted command is always fresh
    a_accept_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_verdict == VERDICT_ACCEPT) |-> m_fresh)
        else $error("accepted command reported stale");

    // a query changes no stored status
    a_query_status: assert property (@(posedge aclk) disable iff (!aresetn)
        query_word |-> status_same)
        else $error("query word changed stored status or counters");

endmodule

bind can_command_frame_checker_unit ccfc_checker u_ccfc_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_verdict           (m_verdict),
    .m_enable_out        (m_enable_out),
    .m_fresh             (m_fresh),
    .m_last_counter      (m_last_counter),
    .m_count_accepted    (m_count_accepted),
    .m_count_bad_id      (m_count_bad_id),
    .m_count_bad_type    (m_count_bad_type),
    .m_count_bad_length  (m_count_bad_length),
    .m_count_bad_value   (m_count_bad_value),
    .m_count_bad_counter (m_count_bad_counter)
);

/* dv/tb_can_command_frame_checker_unit.sv */
`timescale 1ns / 100ps
// tb_can_command_frame_checker_unit: self-checking testbench of the CAN command frame checker
// predicts every status word from its own copy of the command state and compares at the output
// depends on ccfc_pkg and can_command_frame_checker_unit
module tb_can_command_frame_checker_unit;
    import ccfc_pkg::*;

    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic                action;
        logic [ID_W-1:0]     frame_id;
        logic                is_ext;
        logic                is_rtr;
        logic [3:0]          dlc;
        logic [7:0]          enable_byte;
        logic [7:0]          counter_byte;
        logic [TIME_W-1:0]   now_ms;
    } frame_word_t;

    typedef struct {
        verdict_t                               verdict;
        logic                                   enable_out;
        logic                                   fresh;
        logic [7:0]                             last_counter;
        logic [NUM_EVENTS-1:0][OUT_COUNT_W-1:0] tally;
    } status_word_t;

    typedef enum int {RCV_ALWAYS, RCV_RANDOM, RCV_PATTERN} rcv_mode_t;

    // dut ports, all inputs known from time zero
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = 1'b0;
    logic [ID_W-1:0] s_frame_id = '0;
    logic s_is_extended = 1'b0;
    logic s_is_remote = 1'b0;
    logic [3:0] s_dlc = '0;
    logic [7:0] s_enable_byte = '0;
    logic [7:0] s_counter_byte = '0;
    logic [TIME_W-1:0] s_now_ms = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_verdict;
    logic m_enable_out;
    logic m_fresh;
    logic [7:0] m_last_counter;
    logic [OUT_COUNT_W-1:0] m_count_accepted;
    logic [OUT_COUNT_W-1:0] m_count_bad_id;
    logic [OUT_COUNT_W-1:0] m_count_bad_type;
    logic [OUT_COUNT_W-1:0] m_count_bad_length;
    logic [OUT_COUNT_W-1:0] m_count_bad_value;
    logic [OUT_COUNT_W-1:0] m_count_bad_counter;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow of the registers and of the stored command
    logic [ID_W-1:0] cmd_id_reg = COMMAND_ID_RESET;
    logic [TIMEOUT_W-1:0] timeout_reg = TIMEOUT_RESET;
    logic held_valid = 1'b0;
    logic held_enable = 1'b0;
    logic [7:0] held_counter = '0;
    logic [TIME_W-1:0] held_time = '0;
    logic [NUM_EVENTS-1:0][OUT_COUNT_W-1:0] event_tally = '0;

    status_word_t pending_status[$];
    int mismatches = 0;

    // sender and receiver pacing
    int burst_left = 0;
    bit steady = 1'b0;
    rcv_mode_t ready_mode = RCV_ALWAYS;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int rcv_tick = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    string tally_name[NUM_EVENTS] = '{"count_accepted", "count_bad_id", "count_bad_type",
                                      "count_bad_length", "count_bad_value", "count_bad_counter"};

    can_command_frame_checker_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_frame_id         (s_frame_id),
        .s_is_extended      (s_is_extended),
        .s_is_remote        (s_is_remote),
        .s_dlc              (s_dlc),
        .s_enable_byte      (s_enable_byte),
        .s_counter_byte     (s_counter_byte),
        .s_now_ms           (s_now_ms),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_verdict          (m_verdict),
        .m_enable_out       (m_enable_out),
        .m_fresh            (m_fresh),
        .m_last_counter     (m_last_counter),
        .m_count_accepted   (m_count_accepted),
        .m_count_bad_id     (m_count_bad_id),
        .m_count_bad_type   (m_count_bad_type),
        .m_count_bad_length (m_count_bad_length),
        .m_count_bad_value  (m_count_bad_value),
        .m_count_bad_counter(m_count_bad_counter),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // stored command is fresh while its age fits in the timeout, age taken mod 2^32
    function automatic logic command_fresh(logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] age;
        age = now - held_time;
        return held_valid && (age <= TIME_W'(timeout_reg));
    endfunction

    // first failing check wins; an accepted frame replaces the stored command
    function automatic status_word_t judge_frame(frame_word_t w);
        status_word_t r;
        verdict_t v;
        v = VERDICT_QUERY;
        if (!w.action) begin
            if (w.frame_id != cmd_id_reg)
                v = VERDICT_BAD_ID;
            else if (w.is_ext || w.is_rtr)
                v = VERDICT_BAD_TYPE;
            else if (w.dlc != CMD_DLC)
                v = VERDICT_BAD_LENGTH;
            else if (w.enable_byte > ENABLE_MAX)
                v = VERDICT_BAD_VALUE;
            else if (command_fresh(w.now_ms) && w.counter_byte != 8'(held_counter + 8'd1))
                v = VERDICT_BAD_COUNTER;
            else
                v = VERDICT_ACCEPT;
            if (v == VERDICT_ACCEPT) begin
                held_valid = 1'b1;
                held_enable = w.enable_byte[0];
                held_counter = w.counter_byte;
                held_time = w.now_ms;
            end
            event_tally[int'(v) - 1] = event_tally[int'(v) - 1] + 1'b1;
        end
        r.verdict = v;
        r.enable_out = held_enable;
        r.fresh = command_fresh(w.now_ms);
        r.last_counter = held_counter;
        r.tally = event_tally;
        return r;
    endfunction

    function automatic frame_word_t make_frame(logic action, logic [ID_W-1:0] fid, logic ext,
                                               logic rtr, logic [3:0] dlc, logic [7:0] en,
                                               logic [7:0] ctr, logic [TIME_W-1:0] now);
        frame_word_t w;
        w.action = action;
        w.frame_id = fid;
        w.is_ext = ext;
        w.is_rtr = rtr;
        w.dlc = dlc;
        w.enable_byte = en;
        w.counter_byte = ctr;
        w.now_ms = now;
        return w;
    endfunction

    // well-formed command frame for the current identifier
    function automatic frame_word_t cmd_frame(logic [7:0] en, logic [7:0] ctr,
                                              logic [TIME_W-1:0] now);
        return make_frame(1'b0, cmd_id_reg, 1'b0, 1'b0, CMD_DLC, en, ctr, now);
    endfunction

    function automatic frame_word_t query_at(logic [TIME_W-1:0] now);
        return make_frame(1'b1, cmd_id_reg, 1'b0, 1'b0, CMD_DLC, 8'd0, 8'd0, now);
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // offer one word in bursts with random gaps, predict once it is taken
    task automatic send_word(frame_word_t w);
        int gap;
        if (!steady && burst_left == 0) begin
            gap = $urandom_range(0, 7);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_valid <= 1'b1;
        s_action <= w.action;
        s_frame_id <= w.frame_id;
        s_is_extended <= w.is_ext;
        s_is_remote <= w.is_rtr;
        s_dlc <= w.dlc;
        s_enable_byte <= w.enable_byte;
        s_counter_byte <= w.counter_byte;
        s_now_ms <= w.now_ms;
        do @(posedge aclk); while (!s_ready);
        pending_status.push_back(judge_frame(w));
    endtask

    // stop offering and wait for every outstanding status word
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_status.size() != 0)
            @(posedge aclk);
    endtask

    // leaves cfg_valid high so back-to-back writes keep one assignment per step
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_COMMAND_ID: cmd_id_reg = data[ID_W-1:0];
            REG_TIMEOUT_MS: timeout_reg = data[TIMEOUT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] id, logic [CFG_DATA_W-1:0] tmo);
        drain();
        write_reg(REG_COMMAND_ID, id);
        write_reg(REG_TIMEOUT_MS, tmo);
        cfg_valid <= 1'b0;
    endtask

    // receiver: long hold on request, otherwise the current stall pattern
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            case (ready_mode)
                RCV_ALWAYS: m_ready <= 1'b1;
                RCV_RANDOM: m_ready <= ($urandom_range(0, 9) < 7);
                default:    m_ready <= ((rcv_tick % 13) >= 4);
            endcase
        end
        rcv_tick++;
    end

    // compare each status word with the oldest prediction
    always @(posedge aclk) begin
        status_word_t want;
        logic [NUM_EVENTS-1:0][OUT_COUNT_W-1:0] got_tally;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $error("status word with verdict %0d arrived with none expected", m_verdict);
                mismatches++;
            end else begin
                want = pending_status.pop_front();
                got_tally = {m_count_bad_counter, m_count_bad_value, m_count_bad_length,
                             m_count_bad_type, m_count_bad_id, m_count_accepted};
                check_field("verdict", want.verdict, m_verdict);
                check_field("enable_out", want.enable_out, m_enable_out);
                check_field("fresh", want.fresh, m_fresh);
                check_field("last_counter", want.last_counter, m_last_counter);
                for (int i = 0; i < NUM_EVENTS; i++)
                    check_field(tally_name[i], want.tally[i], got_tally[i]);
            end
        end
    end

    // queries, acceptance and each rejection with the default registers
    task automatic test_frame_checks();
        send_word(make_frame(1'b1, '1, 1'b1, 1'b1, 4'hF, 8'hFF, 8'hFF, 32'd0));
        send_word(cmd_frame(8'd1, 8'h37, 32'd1000));
        send_word(query_at(32'd1100));
        send_word(query_at(32'd1101));
        // stale command takes any counter
        send_word(cmd_frame(8'd1, 8'h50, 32'd1101));
        send_word(cmd_frame(8'd1, 8'h52, 32'd1150));
        send_word(cmd_frame(8'd0, 8'h51, 32'd1150));
        // identifier is checked before type and length
        send_word(make_frame(1'b0, 29'd1, 1'b1, 1'b0, 4'd5, 8'd0, 8'h52, 32'd1160));
        send_word(make_frame(1'b0, '1, 1'b0, 1'b0, CMD_DLC, 8'd0, 8'h52, 32'd1160));
        send_word(make_frame(1'b0, cmd_id_reg, 1'b1, 1'b0, CMD_DLC, 8'd0, 8'h52, 32'd1160));
        send_word(make_frame(1'b0, cmd_id_reg, 1'b0, 1'b1, 4'd0, 8'd0, 8'h52, 32'd1160));
        send_word(make_frame(1'b0, cmd_id_reg, 1'b0, 1'b0, 4'd0, 8'd0, 8'h52, 32'd1160));
        send_word(make_frame(1'b0, cmd_id_reg, 1'b0, 1'b0, 4'd15, 8'd0, 8'h52, 32'd1160));
        send_word(make_frame(1'b0, cmd_id_reg, 1'b0, 1'b0, 4'd9, 8'd1, 8'h52, 32'd1160));
        send_word(cmd_frame(8'd2, 8'h52, 32'd1170));
        // bad value wins over a counter break
        send_word(cmd_frame(8'hFF, 8'h99, 32'd1170));
        // counter wrap across the time wrap
        send_word(cmd_frame(8'd1, 8'hFF, 32'hFFFF_FFC0));
        send_word(cmd_frame(8'd1, 8'h00, 32'h0000_0020));
        send_word(query_at(32'h0000_0010));
    endtask

    // masked writes, ignored indexes, shortest and longest timeout
    task automatic test_register_extremes();
        drain();
        write_reg(REG_COMMAND_ID, 32'hFFFF_FFFF);
        write_reg(REG_TIMEOUT_MS, 32'd0);
        write_reg(4'd2, 32'd0);
        write_reg(4'd15, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_word(cmd_frame(8'd0, 8'd5, 32'd500));
        send_word(query_at(32'd500));
        send_word(cmd_frame(8'd1, 8'd9, 32'd501));
        set_config(32'h1FFF_FFFF, 32'h0001_FFFF);
        send_word(query_at(32'd501 + 32'd65535));
        send_word(query_at(32'd501 + 32'd65536));
    endtask

    // block fills while the result side holds off, then the sender waits it out
    task automatic test_backpressure();
        set_config(32'h0ABC_1234, 32'd100);
        clock_ms = 32'd20_000;
        ready_mode = RCV_ALWAYS;
        steady = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
            clock_ms += 32'd3;
            send_word(cmd_frame(8'($urandom_range(0, 1)), 8'(held_counter + 8'd1), clock_ms));
        end
        steady = 1'b0;
        drain();
        ready_mode = RCV_PATTERN;
        for (int i = 0; i < 20; i++) begin
            clock_ms += 32'd5;
            send_word(cmd_frame(8'($urandom_range(0, 1)), 8'(held_counter + 8'd1), clock_ms));
        end
    endtask

    // mostly well-formed command streams, plus queries, breaks and noise
    task automatic run_random(int n);
        frame_word_t w;
        int pick;
        int step_pick;
        for (int i = 0; i < n; i++) begin
            step_pick = $urandom_range(0, 99);
            if (step_pick < 75)
                clock_ms += TIME_W'($urandom_range(0, int'(timeout_reg) / 2 + 1));
            else if (step_pick < 95)
                clock_ms += TIME_W'($urandom_range(0, 2 * int'(timeout_reg) + 5));
            else
                clock_ms = $urandom;
            w = cmd_frame(8'($urandom_range(0, 1)), 8'(held_counter + 8'd1), clock_ms);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                w = make_frame(1'b1, ID_W'($urandom), 1'($urandom), 1'($urandom), 4'($urandom),
                               8'($urandom), 8'($urandom), clock_ms);
            end else if (pick < 16) begin
                w.counter_byte = 8'($urandom);
            end else if (pick < 22) begin
                w.frame_id = ID_W'($urandom);
            end else if (pick < 26) begin
                w.is_ext = 1'($urandom);
                w.is_rtr = 1'($urandom);
            end else if (pick < 31) begin
                w.dlc = 4'($urandom);
            end else if (pick < 35) begin
                w.enable_byte = 8'($urandom);
            end else if (pick < 40) begin
                w = make_frame(1'b0, ID_W'($urandom), 1'($urandom), 1'($urandom), 4'($urandom),
                               8'($urandom), 8'($urandom), clock_ms);
            end
            send_word(w);
        end
    endtask

    // one random stretch per register setting, receiver behavior varied
    task automatic test_random_phases();
        set_config($urandom, 32'd100);
        ready_mode = RCV_RANDOM;
        run_random(210);
        set_config(32'd0, 32'd0);
        ready_mode = RCV_ALWAYS;
        steady = 1'b1;
        run_random(210);
        steady = 1'b0;
        set_config(32'h1FFF_FFFF, 32'd65535);
        clock_ms = 32'hFFFF_0000;
        ready_mode = RCV_PATTERN;
        run_random(210);
        set_config($urandom, 32'd1);
        ready_mode = RCV_RANDOM;
        hold_req = 1'b1;
        run_random(210);
        set_config($urandom, $urandom);
        ready_mode = RCV_PATTERN;
        run_random(210);
        set_config($urandom, $urandom_range(0, 300));
        ready_mode = RCV_RANDOM;
        run_random(210);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_frame_checks();
        test_register_extremes();
        test_backpressure();
        test_random_phases();
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_can_command_frame_checker_unit OK");
        else
            $display("tb_can_command_frame_checker_unit NOT OK");
        $finish;
    end

    // run limit, far above the slowest passing run
    initial begin
        #2_000_000;
        $display("tb_can_command_frame_checker_unit NOT OK");
        $finish;
    end

endmodule
